// File: hdl/hvn_pkg.sv
// ----------------------------------------------------------------------------
// Heightfield vertex normals: shared package
// Types, widths and codes used by the vertex normal generator and its
// normalization unit.
// ----------------------------------------------------------------------------
package hvn_pkg;

    localparam int COL_W   = 6;
    localparam int HGT_W   = 16;
    localparam int SIZE_W  = 16;
    localparam int POS_W   = 21;
    localparam int NRM_W   = 16;
    localparam int ACC_W   = 21;
    localparam int MAG_W   = ACC_W;
    localparam int SUM_W   = 2 * MAG_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int FRAC    = 15;
    localparam int NUM_W   = MAG_W + FRAC + 1;
    localparam int DIV_W   = ROOT_W + 1;
    localparam int REM_W   = DIV_W + 1;
    localparam int CNT_W   = 5;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 120;
    localparam int CFG_W   = 16;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [FRAC-1:0]  Q_MAX   = 15'd16384;

    typedef enum logic {
        REG_GRID_CELLS = 1'b0,
        REG_CELL_SIZE  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] z;
        logic signed [ACC_W-1:0] y;
        logic signed [ACC_W-1:0] x;
    } acc_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDH0,
        ST_RDH1,
        ST_FACE,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_ACC_SET,
        ST_CLR,
        ST_EM_RD,
        ST_EM_LD,
        ST_EM_WAIT,
        ST_EM_PUT,
        ST_HW0,
        ST_HW1
    } top_state_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SQ,
        N_ROOT,
        N_DINIT,
        N_DIV,
        N_DONE
    } norm_state_t;

endpackage

// File: hdl/hvn_norm.sv
// ----------------------------------------------------------------------------
// Heightfield vertex normals: normalization unit
// Scales an accumulated normal to unit length in Q1.14 with one shared
// squarer, a two-bit-per-cycle square root and a restoring divider.
// ----------------------------------------------------------------------------
module hvn_norm (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  hvn_pkg::acc_t                     vec,
    output logic                              done,
    output logic signed [hvn_pkg::NRM_W-1:0]  nx,
    output logic signed [hvn_pkg::NRM_W-1:0]  ny,
    output logic signed [hvn_pkg::NRM_W-1:0]  nz
);

    hvn_pkg::norm_state_t state_reg, state_next;

    hvn_pkg::acc_t                    vec_reg;
    logic [1:0]                       k_reg;
    logic [hvn_pkg::CNT_W-1:0]        cnt_reg;
    logic [hvn_pkg::SUM_W-1:0]        sum_reg;
    logic [hvn_pkg::SUM_W-1:0]        rad_reg;
    logic [hvn_pkg::ROOT_W+1:0]       rrem_reg;
    logic [hvn_pkg::ROOT_W-1:0]       root_reg;
    logic [hvn_pkg::ROOT_W-1:0]       len_reg;
    logic [hvn_pkg::REM_W-1:0]        drem_reg;
    logic [hvn_pkg::FRAC-1:0]         nlow_reg;
    logic [hvn_pkg::FRAC-1:0]         q_reg;
    logic signed [hvn_pkg::NRM_W-1:0] nx_reg, ny_reg, nz_reg;

    logic signed [hvn_pkg::ACC_W-1:0] comp;
    logic [hvn_pkg::MAG_W-1:0]        mag;
    logic [2*hvn_pkg::MAG_W-1:0]      sq;
    logic [hvn_pkg::ROOT_W+1:0]       rt;
    logic [hvn_pkg::ROOT_W+1:0]       rtrial;
    logic                             rge;
    logic [hvn_pkg::NUM_W-1:0]        num;
    logic [hvn_pkg::DIV_W-1:0]        dvs;
    logic [hvn_pkg::REM_W-1:0]        dt;
    logic                             dge;
    logic [hvn_pkg::FRAC-1:0]         qn;
    logic [hvn_pkg::FRAC-1:0]         qc;
    logic signed [hvn_pkg::NRM_W-1:0] res;

    always_comb begin
        case (k_reg)
            2'd0:    comp = vec_reg.x;
            2'd1:    comp = vec_reg.y;
            default: comp = vec_reg.z;
        endcase
        mag    = comp[hvn_pkg::ACC_W-1] ? hvn_pkg::MAG_W'(-comp) : hvn_pkg::MAG_W'(comp);
        sq     = mag * mag;
        rt     = {rrem_reg[hvn_pkg::ROOT_W-1:0], rad_reg[hvn_pkg::SUM_W-1 -: 2]};
        rtrial = {root_reg, 2'b01};
        rge    = (rt >= rtrial);
        num    = hvn_pkg::NUM_W'({mag, {hvn_pkg::FRAC{1'b0}}})
               + hvn_pkg::NUM_W'(len_reg);
        dvs    = {len_reg, 1'b0};
        dt     = {drem_reg[hvn_pkg::REM_W-2:0], nlow_reg[hvn_pkg::FRAC-1]};
        dge    = (dt >= hvn_pkg::REM_W'(dvs));
        qn     = {q_reg[hvn_pkg::FRAC-2:0], dge};
        qc     = (qn > hvn_pkg::Q_MAX) ? hvn_pkg::Q_MAX : qn;
        res    = comp[hvn_pkg::ACC_W-1] ? -hvn_pkg::NRM_W'(qc) : hvn_pkg::NRM_W'(qc);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hvn_pkg::N_IDLE:  if (start) state_next = hvn_pkg::N_SQ;
            hvn_pkg::N_SQ:    if (k_reg == 2'd2) state_next = hvn_pkg::N_ROOT;
            hvn_pkg::N_ROOT:  if (cnt_reg == hvn_pkg::CNT_W'(hvn_pkg::ROOT_W - 1)) begin
                state_next = hvn_pkg::N_DINIT;
            end
            hvn_pkg::N_DINIT: state_next = hvn_pkg::N_DIV;
            hvn_pkg::N_DIV:   if (cnt_reg == hvn_pkg::CNT_W'(hvn_pkg::FRAC - 1)) begin
                state_next = (k_reg == 2'd2) ? hvn_pkg::N_DONE : hvn_pkg::N_DINIT;
            end
            hvn_pkg::N_DONE:  state_next = hvn_pkg::N_IDLE;
            default:          state_next = hvn_pkg::N_IDLE;
        endcase
    end

    always_comb begin
        done = (state_reg == hvn_pkg::N_DONE);
    end

    assign nx = nx_reg;
    assign ny = ny_reg;
    assign nz = nz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hvn_pkg::N_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            hvn_pkg::N_IDLE: begin
                vec_reg <= vec;
                k_reg   <= 2'd0;
                sum_reg <= '0;
            end
            hvn_pkg::N_SQ: begin
                sum_reg <= sum_reg + hvn_pkg::SUM_W'(sq);
                if (k_reg == 2'd2) begin
                    rad_reg  <= sum_reg + hvn_pkg::SUM_W'(sq);
                    rrem_reg <= '0;
                    root_reg <= '0;
                    cnt_reg  <= '0;
                    k_reg    <= 2'd0;
                end else begin
                    k_reg <= k_reg + 2'd1;
                end
            end
            hvn_pkg::N_ROOT: begin
                rad_reg <= rad_reg << 2;
                cnt_reg <= cnt_reg + 1'b1;
                if (rge) begin
                    rrem_reg <= rt - rtrial;
                    root_reg <= {root_reg[hvn_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    rrem_reg <= rt;
                    root_reg <= {root_reg[hvn_pkg::ROOT_W-2:0], 1'b0};
                end
                if (cnt_reg == hvn_pkg::CNT_W'(hvn_pkg::ROOT_W - 1)) begin
                    if (rge) begin
                        len_reg <= {root_reg[hvn_pkg::ROOT_W-2:0], 1'b1};
                    end else if (root_reg == '0) begin
                        len_reg <= hvn_pkg::ROOT_W'(1);
                    end else begin
                        len_reg <= {root_reg[hvn_pkg::ROOT_W-2:0], 1'b0};
                    end
                end
            end
            hvn_pkg::N_DINIT: begin
                drem_reg <= hvn_pkg::REM_W'(num[hvn_pkg::NUM_W-1:hvn_pkg::FRAC]);
                nlow_reg <= num[hvn_pkg::FRAC-1:0];
                q_reg    <= '0;
                cnt_reg  <= '0;
            end
            hvn_pkg::N_DIV: begin
                drem_reg <= dge ? (dt - hvn_pkg::REM_W'(dvs)) : dt;
                nlow_reg <= nlow_reg << 1;
                q_reg    <= qn;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == hvn_pkg::CNT_W'(hvn_pkg::FRAC - 1)) begin
                    case (k_reg)
                        2'd0:    nx_reg <= res;
                        2'd1:    ny_reg <= res;
                        default: nz_reg <= res;
                    endcase
                    k_reg <= k_reg + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: hdl/heightfield_vertex_normals_top.sv
// A height on row 0 or column 0 clears its accumulator and is stored; one that
// closes a cell also adds its face normals and emits each of its one to four vertices.
// One height at a time: the next beat is accepted once the block is back in idle.
// Reset: synchronous, active low; registers return to 32 cells of size 256 and
// the grid restarts at row 0, column 0. The row memories need no clearing.
// ----------------------------------------------------------------------------
// Heightfield vertex normals: top level
// Takes grid heights in raster order, accumulates triangle face normals into
// two rows of vertices and emits each vertex with its unit normal once done.
// ----------------------------------------------------------------------------
module heightfield_vertex_normals_top #(
    parameter int MAX_CELLS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hvn_pkg::IN_W-1:0]      s_tdata,   // [15:0] height
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [5:0] vert_col, [11:6] vert_row, [32:12] pos_x, [53:33] pos_z,
    // [69:54] pos_height, [85:70] normal_x, [101:86] normal_y, [117:102] normal_z
    output logic [hvn_pkg::OUT_W-1:0]     m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [hvn_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int ROW_SPAN = MAX_CELLS + 1;
    localparam int ACC_D    = 2 * ROW_SPAN;
    localparam int ROW_AW   = $clog2(ROW_SPAN);
    localparam int ACC_AW   = $clog2(ACC_D);
    localparam logic [hvn_pkg::COL_W-1:0] MAXC = (MAX_CELLS > 63) ? 6'd63 : 6'(MAX_CELLS);

    typedef logic signed [hvn_pkg::HGT_W-1:0] hgt_t;
    typedef logic signed [hvn_pkg::HGT_W:0]   dif_t;

    hvn_pkg::top_state_t state_reg, state_next;

    logic [hvn_pkg::COL_W-1:0]  grid_reg;
    logic [hvn_pkg::SIZE_W-1:0] csize_reg;
    logic [hvn_pkg::COL_W-1:0]  c_reg, r_reg;
    hgt_t                       left_reg, h_reg, h00_reg, h10_reg;
    dif_t                       ax_reg, az_reg, bx_reg, bz_reg;
    logic [1:0]                 k_reg;
    logic [3:0]                 mask_reg;
    logic [hvn_pkg::POS_W-1:0]  posx_reg, posz_reg;

    logic                       m_valid_reg;
    logic [hvn_pkg::COL_W-1:0]  o_col_reg, o_row_reg;
    logic [hvn_pkg::POS_W-1:0]  o_px_reg, o_pz_reg;
    hgt_t                       o_h_reg;
    logic signed [hvn_pkg::NRM_W-1:0] o_nx_reg, o_ny_reg, o_nz_reg;
    logic                       o_last_reg;

    hvn_pkg::acc_t              acc_mem [ACC_D];
    hvn_pkg::acc_t              acc_rd_reg;
    hvn_pkg::acc_t              acc_wdata;
    logic [ACC_AW-1:0]          acc_raddr, acc_waddr;
    logic                       acc_we;

    hgt_t                       hgt_mem [ROW_SPAN];
    hgt_t                       hrd_reg;
    hgt_t                       h_wdata;
    logic [ROW_AW-1:0]          h_raddr, h_waddr;
    logic                       h_we;

    logic [hvn_pkg::COL_W-1:0]  n_eff;
    logic [hvn_pkg::SIZE_W-1:0] s_eff;
    logic                       cur, prv, closes_cell, edge_c, edge_r;
    logic [hvn_pkg::COL_W-1:0]  cm1, rm1;
    logic [1:0]                 e_idx;
    logic                       e_last;
    logic [hvn_pkg::COL_W-1:0]  e_col, e_row;
    logic                       e_slot;
    hgt_t                       e_hgt;
    logic                       out_free;
    hvn_pkg::acc_t              va, vb, vab, delta;
    logic [hvn_pkg::COL_W+hvn_pkg::SIZE_W-1:0] px_full, pz_full;

    logic                       norm_start, norm_done;
    logic signed [hvn_pkg::NRM_W-1:0] nx, ny, nz;

    function automatic logic [ACC_AW-1:0] acc_addr(input logic slot,
                                                   input logic [hvn_pkg::COL_W-1:0] col);
        acc_addr = slot ? (ACC_AW'(ROW_SPAN) + ACC_AW'(col)) : ACC_AW'(col);
    endfunction

    hvn_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .vec     (acc_rd_reg),
        .done    (norm_done),
        .nx      (nx),
        .ny      (ny),
        .nz      (nz)
    );

    always_comb begin
        if (grid_reg == '0) begin
            n_eff = 6'd1;
        end else if (grid_reg > MAXC) begin
            n_eff = MAXC;
        end else begin
            n_eff = grid_reg;
        end
        s_eff  = (csize_reg == '0) ? 16'd1 : csize_reg;
        cur    = r_reg[0];
        prv    = ~r_reg[0];
        closes_cell = (c_reg != '0) && (r_reg != '0);
        edge_c = (c_reg == n_eff);
        edge_r = (r_reg == n_eff);
        cm1    = c_reg - 1'b1;
        rm1    = r_reg - 1'b1;

        va.x  = hvn_pkg::ACC_W'(ax_reg);
        va.y  = hvn_pkg::ACC_W'(s_eff);
        va.z  = hvn_pkg::ACC_W'(az_reg);
        vb.x  = hvn_pkg::ACC_W'(bx_reg);
        vb.y  = hvn_pkg::ACC_W'(s_eff);
        vb.z  = hvn_pkg::ACC_W'(bz_reg);
        vab.x = va.x + vb.x;
        vab.y = va.y + vb.y;
        vab.z = va.z + vb.z;
        case (k_reg)
            2'd0:    delta = va;
            2'd1:    delta = vab;
            default: delta = vb;
        endcase

        if (mask_reg[0]) begin
            e_idx = 2'd0;
        end else if (mask_reg[1]) begin
            e_idx = 2'd1;
        end else if (mask_reg[2]) begin
            e_idx = 2'd2;
        end else begin
            e_idx = 2'd3;
        end
        e_last = ((mask_reg & (mask_reg - 4'd1)) == 4'd0);
        e_col  = e_idx[0] ? n_eff : cm1;
        e_row  = e_idx[1] ? n_eff : rm1;
        e_slot = e_idx[1] ? cur : prv;
        case (e_idx)
            2'd0:    e_hgt = h00_reg;
            2'd1:    e_hgt = h10_reg;
            2'd2:    e_hgt = left_reg;
            default: e_hgt = h_reg;
        endcase
        px_full  = e_col * csize_reg;
        pz_full  = e_row * csize_reg;
        out_free = !m_valid_reg || m_tready;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hvn_pkg::ST_IDLE:    if (s_tvalid) state_next = hvn_pkg::ST_RDH0;
            hvn_pkg::ST_RDH0:    state_next = hvn_pkg::ST_RDH1;
            hvn_pkg::ST_RDH1:    state_next = hvn_pkg::ST_FACE;
            hvn_pkg::ST_FACE:    state_next = closes_cell ? hvn_pkg::ST_ACC_RD
                                                          : hvn_pkg::ST_CLR;
            hvn_pkg::ST_ACC_RD:  state_next = hvn_pkg::ST_ACC_WR;
            hvn_pkg::ST_ACC_WR:  state_next = (k_reg == 2'd2) ? hvn_pkg::ST_ACC_SET
                                                              : hvn_pkg::ST_ACC_RD;
            hvn_pkg::ST_ACC_SET: state_next = hvn_pkg::ST_EM_RD;
            hvn_pkg::ST_CLR:     state_next = hvn_pkg::ST_HW0;
            hvn_pkg::ST_EM_RD:   state_next = hvn_pkg::ST_EM_LD;
            hvn_pkg::ST_EM_LD:   state_next = hvn_pkg::ST_EM_WAIT;
            hvn_pkg::ST_EM_WAIT: if (norm_done) state_next = hvn_pkg::ST_EM_PUT;
            hvn_pkg::ST_EM_PUT:  if (out_free) begin
                state_next = e_last ? hvn_pkg::ST_HW0 : hvn_pkg::ST_EM_RD;
            end
            hvn_pkg::ST_HW0:     state_next = hvn_pkg::ST_HW1;
            hvn_pkg::ST_HW1:     state_next = hvn_pkg::ST_IDLE;
            default:             state_next = hvn_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = (state_reg == hvn_pkg::ST_IDLE);
        norm_start = (state_reg == hvn_pkg::ST_EM_LD);
        h_raddr    = (state_reg == hvn_pkg::ST_RDH0) ? ROW_AW'(cm1) : ROW_AW'(c_reg);
        h_we       = 1'b0;
        h_waddr    = ROW_AW'(cm1);
        h_wdata    = left_reg;
        acc_we     = 1'b0;
        acc_waddr  = acc_addr(cur, c_reg);
        acc_wdata  = '0;
        acc_raddr  = acc_addr(e_slot, e_col);
        unique case (state_reg)
            hvn_pkg::ST_ACC_RD, hvn_pkg::ST_ACC_WR: begin
                case (k_reg)
                    2'd0:    acc_raddr = acc_addr(prv, c_reg);
                    2'd1:    acc_raddr = acc_addr(prv, cm1);
                    default: acc_raddr = acc_addr(cur, cm1);
                endcase
                if (state_reg == hvn_pkg::ST_ACC_WR) begin
                    acc_we      = 1'b1;
                    acc_waddr   = acc_raddr;
                    acc_wdata.x = acc_rd_reg.x + delta.x;
                    acc_wdata.y = acc_rd_reg.y + delta.y;
                    acc_wdata.z = acc_rd_reg.z + delta.z;
                end
            end
            hvn_pkg::ST_ACC_SET: begin
                acc_we    = 1'b1;
                acc_wdata = vab;
            end
            hvn_pkg::ST_CLR: begin
                acc_we = 1'b1;
            end
            hvn_pkg::ST_HW0: begin
                h_we = (c_reg != '0);
            end
            hvn_pkg::ST_HW1: begin
                h_we    = edge_c;
                h_waddr = ROW_AW'(n_eff);
                h_wdata = h_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (acc_we) begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        acc_rd_reg <= acc_mem[acc_raddr];
        if (h_we) begin
            hgt_mem[h_waddr] <= h_wdata;
        end
        hrd_reg <= hgt_mem[h_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hvn_pkg::ST_IDLE;
            grid_reg    <= 6'd32;
            csize_reg   <= 16'd256;
            c_reg       <= '0;
            r_reg       <= '0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == hvn_pkg::ST_EM_PUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (hvn_pkg::cfg_reg_t'(cfg_addr))
                    hvn_pkg::REG_GRID_CELLS: grid_reg  <= cfg_wdata[hvn_pkg::COL_W-1:0];
                    hvn_pkg::REG_CELL_SIZE:  csize_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
                c_reg <= '0;
                r_reg <= '0;
            end else if (state_reg == hvn_pkg::ST_HW1) begin
                left_reg <= h_reg;
                if (c_reg >= n_eff) begin
                    c_reg <= '0;
                    r_reg <= (r_reg >= n_eff) ? '0 : r_reg + 1'b1;
                end else begin
                    c_reg <= c_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            hvn_pkg::ST_IDLE: begin
                h_reg <= hgt_t'(s_tdata);
                k_reg <= 2'd0;
            end
            hvn_pkg::ST_FACE: begin
                h10_reg  <= hrd_reg;
                ax_reg   <= dif_t'(h00_reg) - dif_t'(hrd_reg);
                az_reg   <= dif_t'(hrd_reg) - dif_t'(h_reg);
                bx_reg   <= dif_t'(left_reg) - dif_t'(h_reg);
                bz_reg   <= dif_t'(h00_reg) - dif_t'(left_reg);
                mask_reg <= {edge_c & edge_r, edge_r, edge_c, 1'b1};
            end
            hvn_pkg::ST_ACC_WR: begin
                k_reg <= k_reg + 2'd1;
            end
            hvn_pkg::ST_EM_LD: begin
                posx_reg <= (px_full > 22'(hvn_pkg::POS_MAX)) ? hvn_pkg::POS_MAX
                                                              : hvn_pkg::POS_W'(px_full);
                posz_reg <= (pz_full > 22'(hvn_pkg::POS_MAX)) ? hvn_pkg::POS_MAX
                                                              : hvn_pkg::POS_W'(pz_full);
            end
            hvn_pkg::ST_EM_PUT: begin
                if (out_free) begin
                    o_col_reg  <= e_col;
                    o_row_reg  <= e_row;
                    o_px_reg   <= posx_reg;
                    o_pz_reg   <= posz_reg;
                    o_h_reg    <= e_hgt;
                    o_nx_reg   <= nx;
                    o_ny_reg   <= ny;
                    o_nz_reg   <= nz;
                    o_last_reg <= e_last;
                    mask_reg[e_idx] <= 1'b0;
                end
            end
            default: begin
            end
        endcase
        if (state_reg == hvn_pkg::ST_RDH1) begin
            h00_reg <= hrd_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {2'b00, o_nz_reg, o_ny_reg, o_nx_reg, o_h_reg,
                       o_pz_reg, o_px_reg, o_row_reg, o_col_reg};

endmodule

// File: hdl/hvn_checker.sv
// ----------------------------------------------------------------------------
// Heightfield vertex normals: port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module hvn_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [hvn_pkg::OUT_W-1:0] m_tdata,
    input logic                      m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a height is in work");

    a_ny_not_negative: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[101])
        else $error("vertical normal component negative");

endmodule

bind heightfield_vertex_normals_top hvn_checker u_hvn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: sim/heightfield_vertex_normals_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heightfield vertex normals: testbench
// Streams grids of heights through the block under several grid and cell
// size settings, predicts every emitted vertex with its own copy of the
// row stores and accumulators, and compares each result beat field by field.
// ----------------------------------------------------------------------------
module heightfield_vertex_normals_top_tb;

    localparam int ROW_SPAN   = 33;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 400;

    typedef struct {
        logic [5:0]  col;
        logic [5:0]  row;
        logic [20:0] px;
        logic [20:0] pz;
        logic [15:0] hgt;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        last;
    } vertex_t;

    class normal_scoreboard;
        logic [5:0]         cells;
        logic [15:0]        size;
        logic signed [15:0] row_above [ROW_SPAN];
        longint             acc [2][ROW_SPAN][3];
        int                 col;
        int                 row;
        logic signed [15:0] left;
        vertex_t            pending_q [$];
        int                 errors;

        function void clear();
            cells = 32;
            size = 256;
            col = 0;
            row = 0;
            left = 0;
            errors = 0;
            foreach (row_above[i]) row_above[i] = 0;
            foreach (acc[i, j, k]) acc[i][j][k] = 0;
        endfunction

        function void write_reg(hvn_pkg::cfg_reg_t r, logic [15:0] v);
            if (r == hvn_pkg::REG_GRID_CELLS) begin
                cells = v[5:0];
            end else begin
                size = v;
            end
            col = 0;
            row = 0;
        endfunction

        function void add(int slot, int c, longint x, longint y, longint z);
            acc[slot][c][0] += x;
            acc[slot][c][1] += y;
            acc[slot][c][2] += z;
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function logic [15:0] unit_part(longint v, longint unsigned len);
            longint unsigned m;
            longint unsigned q;
            m = (v < 0) ? -v : v;
            q = (32768 * m + len) / (2 * len);
            if (q > 16384) q = 16384;
            return (v < 0) ? 16'(-q) : 16'(q);
        endfunction

        function logic [20:0] scaled(int idx);
            longint unsigned p;
            p = idx * longint'(size);
            return (p > 2097151) ? 21'h1FFFFF : 21'(p);
        endfunction

        function void emit(int c, int r, logic signed [15:0] h, int slot, bit last);
            vertex_t v;
            longint x;
            longint y;
            longint z;
            longint unsigned len;
            x = acc[slot][c][0];
            y = acc[slot][c][1];
            z = acc[slot][c][2];
            len = root(x * x + y * y + z * z);
            if (len == 0) len = 1;
            v.col = 6'(c);
            v.row = 6'(r);
            v.px = scaled(c);
            v.pz = scaled(r);
            v.hgt = h;
            v.nx = unit_part(x, len);
            v.ny = unit_part(y, len);
            v.nz = unit_part(z, len);
            v.last = last;
            pending_q.push_back(v);
        endfunction

        function void note(logic signed [15:0] h);
            int n;
            longint s;
            int cur;
            int prv;
            longint ax, az, bx, bz;
            bit ec, er;
            n = (cells == 0) ? 1 : ((cells > 32) ? 32 : int'(cells));
            s = (size == 0) ? 1 : longint'(size);
            cur = row & 1;
            prv = cur ^ 1;
            acc[cur][col][0] = 0;
            acc[cur][col][1] = 0;
            acc[cur][col][2] = 0;
            if (col >= 1 && row >= 1) begin
                ax = longint'(row_above[col-1]) - row_above[col];
                az = longint'(row_above[col]) - h;
                bx = longint'(left) - h;
                bz = longint'(row_above[col-1]) - left;
                ec = (col == n);
                er = (row == n);
                add(prv, col, ax, s, az);
                add(cur, col, ax, s, az);
                add(prv, col - 1, ax, s, az);
                add(prv, col - 1, bx, s, bz);
                add(cur, col, bx, s, bz);
                add(cur, col - 1, bx, s, bz);
                emit(col - 1, row - 1, row_above[col-1], prv, !ec && !er);
                if (ec) emit(n, row - 1, row_above[col], prv, !er);
                if (er) emit(col - 1, n, left, cur, !ec);
                if (ec && er) emit(n, n, h, cur, 1'b1);
            end
            if (col >= 1) row_above[col-1] = left;
            if (col == n) row_above[n] = h;
            left = h;
            col++;
            if (col > n) begin
                col = 0;
                row++;
                if (row > n) row = 0;
            end
        endfunction

        function void compare(string name, logic [20:0] e, logic [20:0] a);
            if (e !== a) begin
                $error("%s: expected %0h, got %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check(vertex_t got);
            vertex_t e;
            if (pending_q.size() == 0) begin
                $error("vertex beat (%0d,%0d) with none expected", got.col, got.row);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            compare("vert_col", e.col, got.col);
            compare("vert_row", e.row, got.row);
            compare("pos_x", e.px, got.px);
            compare("pos_z", e.pz, got.pz);
            compare("pos_height", e.hgt, got.hgt);
            compare("normal_x", e.nx, got.nx);
            compare("normal_y", e.ny, got.ny);
            compare("normal_z", e.nz, got.nz);
            compare("last_of_run", e.last, got.last);
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [hvn_pkg::IN_W-1:0]      s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [hvn_pkg::OUT_W-1:0]     m_tdata;
    logic                          m_tlast;
    logic                          cfg_we;
    hvn_pkg::cfg_reg_t             cfg_addr;
    logic [hvn_pkg::CFG_W-1:0]     cfg_wdata;

    normal_scoreboard     sb;
    bit                   no_idle;
    bit                   hold_req;
    int                   quiet_cycles;
    int                   sent;
    logic signed [15:0]   walk;

    heightfield_vertex_normals_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("heightfield_vertex_normals_top_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_height(logic [15:0] h);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = h;
        do @(posedge aclk); while (!s_tready);
        sb.note(h);
        sent++;
        @(negedge aclk);
    endtask

    task automatic drain_and_settle();
        s_tvalid = 1'b0;
        while (sb.pending_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(hvn_pkg::cfg_reg_t r, logic [15:0] v);
        cfg_we = 1'b1;
        cfg_addr = r;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we = 1'b0;
        sb.write_reg(r, v);
    endtask

    task automatic set_grid(logic [15:0] cells, logic [15:0] size);
        drain_and_settle();
        if ($urandom_range(0, 1)) begin
            write_reg(hvn_pkg::REG_GRID_CELLS, cells);
            write_reg(hvn_pkg::REG_CELL_SIZE, size);
        end else begin
            write_reg(hvn_pkg::REG_CELL_SIZE, size);
            write_reg(hvn_pkg::REG_GRID_CELLS, cells);
        end
    endtask

    function automatic logic [15:0] next_height();
        if ($urandom_range(0, 6) == 0) begin
            walk = $urandom;
        end else begin
            walk = walk + $signed($urandom_range(0, 1024)) - 512;
        end
        return walk;
    endfunction

    initial begin
        vertex_t got;
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (300) @(negedge aclk);
                hold_req = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.col  = m_tdata[5:0];
            got.row  = m_tdata[11:6];
            got.px   = m_tdata[32:12];
            got.pz   = m_tdata[53:33];
            got.hgt  = m_tdata[69:54];
            got.nx   = m_tdata[85:70];
            got.ny   = m_tdata[101:86];
            got.nz   = m_tdata[117:102];
            got.last = m_tlast;
            sb.check(got);
        end
    end

    initial begin
        int n;
        int count;
        logic [15:0] cells;
        logic [15:0] size;
        logic [15:0] corner_h [12];
        sb = new();
        sb.clear();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = hvn_pkg::REG_GRID_CELLS;
        cfg_wdata = '0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        quiet_cycles = 0;
        sent = 0;
        walk = 0;
        corner_h = '{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000,
                     16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000};
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings, single-cell grids (the first with extreme heights), then 63 cells.
        repeat (40) send_height(next_height());
        set_grid(1, 0);
        foreach (corner_h[i]) send_height(corner_h[i]);
        set_grid(0, 16'hFFFF);
        repeat (4) send_height($urandom);
        set_grid(63, 16'hFFFF);
        repeat (60) send_height(next_height());

        // The receiver holds off at the start of each random grid begun before 140 heights are sent.
        while (sent < 430) begin
            case ($urandom_range(0, 9))
                0: cells = 32;
                1: cells = $urandom_range(33, 63);
                2: cells = 0;
                default: cells = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 5))
                0: size = 0;
                1: size = 1;
                2: size = 16'hFFFF;
                default: size = $urandom;
            endcase
            set_grid(cells, size);
            no_idle = ($urandom_range(0, 3) == 0);
            if (sent < 140) hold_req = 1'b1;
            n = (cells == 0) ? 1 : ((cells > 32) ? 32 : int'(cells));
            if (n > 8) begin
                count = $urandom_range(40, 90);
            end else begin
                count = $urandom_range(1, 3) * (n + 1) * (n + 1);
                if ($urandom_range(0, 3) == 0) count = count - $urandom_range(1, n);
            end
            if (count > 430 - sent) count = 430 - sent;
            repeat (count) send_height(next_height());
        end
        drain_and_settle();

        if (sb.errors == 0) begin
            $display("heightfield_vertex_normals_top_tb: PASS");
        end else begin
            $display("heightfield_vertex_normals_top_tb: FAIL");
        end
        $finish;
    end

endmodule
